FILE: rtl/core/rslt_pkg.sv
`timescale 1ns / 1ps
// Shared types for the radio signal level tracker.
// No dependencies; imported by the interfaces and all core modules.
package rslt_pkg;

    localparam int LevelW = 16;
    localparam int FlagW  = 32;
    localparam int RateW  = 16;

    typedef logic signed [LevelW-1:0] level_t;
    typedef logic [FlagW-1:0]         flags_t;
    typedef logic [RateW-1:0]         rate_t;

    // Unit kind codes; code 3 carries no meaning and is handled as other.
    typedef enum logic [1:0] {
        KIND_OTHER = 2'd0,
        KIND_DBM   = 2'd1,
        KIND_RSSI  = 2'd2
    } kind_t;

    // One report as held in the input register.
    typedef struct packed {
        logic   report_present;
        logic [1:0] unit_kind;
        level_t dbm_signal;
        level_t dbm_noise;
        level_t rssi_signal;
        level_t rssi_noise;
        flags_t carrier_flags;
        flags_t encoding_flags;
        rate_t  data_rate;
    } report_t;

    // Running last / min / max of one reading.
    typedef struct packed {
        level_t last;
        level_t lo;
        level_t hi;
    } level_track_t;

endpackage

FILE: rtl/core/rslt_rpt_if.sv
`timescale 1ns / 1ps
// Report request channel: valid/ready handshake plus report fields.
// Depends on rslt_pkg.
interface rslt_rpt_if
    import rslt_pkg::*;
();
    logic   valid;
    logic   ready;
    logic   report_present;
    logic [1:0] unit_kind;
    level_t dbm_signal;
    level_t dbm_noise;
    level_t rssi_signal;
    level_t rssi_noise;
    flags_t carrier_flags;
    flags_t encoding_flags;
    rate_t  data_rate;

    modport source (
        output valid, report_present, unit_kind, dbm_signal, dbm_noise,
               rssi_signal, rssi_noise, carrier_flags, encoding_flags, data_rate,
        input  ready
    );
    modport sink (
        input  valid, report_present, unit_kind, dbm_signal, dbm_noise,
               rssi_signal, rssi_noise, carrier_flags, encoding_flags, data_rate,
        output ready
    );
endinterface

FILE: rtl/core/rslt_lvl_if.sv
`timescale 1ns / 1ps
// Level result channel: valid/ready handshake plus tracked levels and sets.
// Depends on rslt_pkg.
interface rslt_lvl_if
    import rslt_pkg::*;
();
    logic   valid;
    logic   ready;
    logic [1:0] locked_kind;
    level_t last_signal_level;
    level_t last_noise_level;
    level_t min_signal_level;
    level_t max_signal_level;
    level_t min_noise_level;
    level_t max_noise_level;
    rate_t  peak_rate;
    flags_t carrier_seen;
    flags_t encoding_seen;

    modport source (
        output valid, locked_kind, last_signal_level, last_noise_level,
               min_signal_level, max_signal_level, min_noise_level,
               max_noise_level, peak_rate, carrier_seen, encoding_seen,
        input  ready
    );
    modport sink (
        input  valid, locked_kind, last_signal_level, last_noise_level,
               min_signal_level, max_signal_level, min_noise_level,
               max_noise_level, peak_rate, carrier_seen, encoding_seen,
        output ready
    );
endinterface

FILE: rtl/core/radio_signal_level_tracker.sv
`timescale 1ns / 1ps
// Radio signal level tracker top level.
// Depends on rslt_pkg, rslt_rpt_if, rslt_lvl_if, rslt_in_stage, rslt_level_unit.

// One report request enters per clock unless the result side stalls; each
// produces exactly one result that shows the tracker state after that report.
// A request lands in the input register, and then a single pass of compares
// and ORs updates the tracking registers, which are themselves the result
// payload. The result shows valid once the request has moved from the input
// register into the tracking registers; throughput is one report per cycle
// while the result side takes every cycle. The first present
// report in dBm or RSSI locks the unit; later reports in the other unit leave
// the levels alone but still feed the carrier/encoding sets and peak rate.
// A zero reading means absent; a zero min or max means unset. Reports with
// report_present low return the unchanged state. No clearing pass after reset.
module radio_signal_level_tracker
    import rslt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    rslt_rpt_if.sink   rpt,
    rslt_lvl_if.source res
);
    logic    item_valid;
    report_t item;
    logic    advance;

    // Tracking state, doubling as the result register.
    kind_t        kind_reg, kind_next;
    level_track_t sig_reg, sig_next;
    level_track_t noi_reg, noi_next;
    rate_t        rate_reg, rate_next;
    flags_t       carrier_reg, carrier_next;
    flags_t       encoding_reg, encoding_next;
    logic         out_valid_reg, out_valid_next;

    logic   use_dbm;
    logic   use_rssi;
    level_t sig_sample;
    level_t noi_sample;

    rslt_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .rpt        (rpt),
        .take       (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // Held item moves on when the result slot is free or being drained.
    assign advance = item_valid && (!out_valid_reg || res.ready);

    // Unit lock: first dBm/RSSI report wins; code 3 counts as other.
    always_comb
    begin
        use_dbm  = 1'b0;
        use_rssi = 1'b0;
        if (item.report_present)
        begin
            case (item.unit_kind)
                KIND_DBM:
                begin
                    use_dbm = (kind_reg == KIND_OTHER) || (kind_reg == KIND_DBM);
                end
                KIND_RSSI:
                begin
                    use_rssi = (kind_reg == KIND_OTHER) || (kind_reg == KIND_RSSI);
                end
                default:
                begin
                    use_dbm  = 1'b0;
                    use_rssi = 1'b0;
                end
            endcase
        end
    end

    assign sig_sample = use_rssi ? item.rssi_signal : item.dbm_signal;
    assign noi_sample = use_rssi ? item.rssi_noise  : item.dbm_noise;

    rslt_level_unit u_sig_unit (
        .en     (use_dbm || use_rssi),
        .sample (sig_sample),
        .cur    (sig_reg),
        .nxt    (sig_next)
    );

    rslt_level_unit u_noi_unit (
        .en     (use_dbm || use_rssi),
        .sample (noi_sample),
        .cur    (noi_reg),
        .nxt    (noi_next)
    );

    always_comb
    begin
        kind_next     = kind_reg;
        rate_next     = rate_reg;
        carrier_next  = carrier_reg;
        encoding_next = encoding_reg;
        if (use_dbm)
        begin
            kind_next = KIND_DBM;
        end
        else if (use_rssi)
        begin
            kind_next = KIND_RSSI;
        end
        // Sets and peak rate follow every present report, any unit.
        if (item.report_present)
        begin
            carrier_next  = carrier_reg | item.carrier_flags;
            encoding_next = encoding_reg | item.encoding_flags;
            if (rate_reg < item.data_rate)
            begin
                rate_next = item.data_rate;
            end
        end
    end

    assign out_valid_next = advance ? 1'b1 : (out_valid_reg && !res.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg      <= KIND_OTHER;
            sig_reg       <= '0;
            noi_reg       <= '0;
            rate_reg      <= '0;
            carrier_reg   <= '0;
            encoding_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                kind_reg     <= kind_next;
                sig_reg      <= sig_next;
                noi_reg      <= noi_next;
                rate_reg     <= rate_next;
                carrier_reg  <= carrier_next;
                encoding_reg <= encoding_next;
            end
        end
    end

    assign res.valid             = out_valid_reg;
    assign res.locked_kind       = kind_reg;
    assign res.last_signal_level = sig_reg.last;
    assign res.last_noise_level  = noi_reg.last;
    assign res.min_signal_level  = sig_reg.lo;
    assign res.max_signal_level  = sig_reg.hi;
    assign res.min_noise_level   = noi_reg.lo;
    assign res.max_noise_level   = noi_reg.hi;
    assign res.peak_rate         = rate_reg;
    assign res.carrier_seen      = carrier_reg;
    assign res.encoding_seen     = encoding_reg;

    // Once locked, the unit kind never falls back to none.
    a_lock_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (kind_reg != KIND_OTHER) |=> (kind_reg != KIND_OTHER))
        else $error("locked unit kind was released");

    // Flag sets only gain bits.
    a_sets_grow: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ((($past(carrier_reg) & ~carrier_reg) == '0) &&
                  (($past(encoding_reg) & ~encoding_reg) == '0)))
        else $error("carrier or encoding set lost a bit");

    // Tracking state moves only with an item.
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> ($stable(sig_reg) && $stable(noi_reg) && $stable(rate_reg)))
        else $error("tracking state changed without an item");

    // A set signal minimum never exceeds the maximum.
    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        (sig_reg.lo != '0) |-> (sig_reg.lo <= sig_reg.hi))
        else $error("signal minimum above maximum");
endmodule

FILE: rtl/core/rslt_in_stage.sv
`timescale 1ns / 1ps
// Input register for report requests.
// Depends on rslt_pkg and rslt_rpt_if.
module rslt_in_stage
    import rslt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    rslt_rpt_if.sink rpt,
    input  logic    take,
    output logic    item_valid,
    output report_t item
);
    logic    valid_reg;
    logic    valid_next;
    report_t item_reg;
    logic    load;

    // Refill when empty or when the held item moves on this cycle.
    assign rpt.ready  = !valid_reg || take;
    assign load       = rpt.valid && rpt.ready;
    assign valid_next = load ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= '{report_present: rpt.report_present,
                          unit_kind:      rpt.unit_kind,
                          dbm_signal:     rpt.dbm_signal,
                          dbm_noise:      rpt.dbm_noise,
                          rssi_signal:    rpt.rssi_signal,
                          rssi_noise:     rpt.rssi_noise,
                          carrier_flags:  rpt.carrier_flags,
                          encoding_flags: rpt.encoding_flags,
                          data_rate:      rpt.data_rate};
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;
endmodule

FILE: rtl/core/rslt_level_unit.sv
`timescale 1ns / 1ps
// Next last/min/max for one reading (signal or noise).
// Depends on rslt_pkg.
module rslt_level_unit
    import rslt_pkg::*;
(
    input  logic         en,
    input  level_t       sample,
    input  level_track_t cur,
    output level_track_t nxt
);
    logic hit;

    // Zero reading is absent; zero stored bound is unset.
    assign hit = en && (sample != '0);

    always_comb
    begin
        nxt = cur;
        if (hit)
        begin
            nxt.last = sample;
            if (cur.lo == '0 || cur.lo > sample)
            begin
                nxt.lo = sample;
            end
            if (cur.hi == '0 || cur.hi < sample)
            begin
                nxt.hi = sample;
            end
        end
    end
endmodule

FILE: tb/radio_signal_level_tracker_checker.sv
`timescale 1ns / 1ps
// Checker for the radio signal level tracker: watches both channels, keeps a
// shadow of the tracker state and compares each result. Depends on rslt_pkg.
module radio_signal_level_tracker_checker
    import rslt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    rslt_rpt_if  rpt,
    rslt_lvl_if  res,
    output int   mismatches,
    output int   results_owed
);

    typedef struct packed {
        logic [1:0]   locked_kind;
        level_track_t sig;
        level_track_t noi;
        rate_t        peak_rate;
        flags_t       carrier_seen;
        flags_t       encoding_seen;
    } tracker_view_t;

    tracker_view_t shadow;
    tracker_view_t views_owed[$];

    // Zero reading is absent; zero lo/hi is unset.
    function automatic level_track_t fold_reading(level_track_t t, level_t v);
        if (v != 0)
        begin
            t.last = v;
            if (t.lo == 0 || $signed(t.lo) > $signed(v))
                t.lo = v;
            if (t.hi == 0 || $signed(t.hi) < $signed(v))
                t.hi = v;
        end
        return t;
    endfunction

    function automatic tracker_view_t fold_report(tracker_view_t s);
        if (!rpt.report_present)
            return s;
        if (rpt.unit_kind == KIND_DBM && s.locked_kind != KIND_RSSI)
        begin
            s.locked_kind = KIND_DBM;
            s.sig = fold_reading(s.sig, rpt.dbm_signal);
            s.noi = fold_reading(s.noi, rpt.dbm_noise);
        end
        else if (rpt.unit_kind == KIND_RSSI && s.locked_kind != KIND_DBM)
        begin
            s.locked_kind = KIND_RSSI;
            s.sig = fold_reading(s.sig, rpt.rssi_signal);
            s.noi = fold_reading(s.noi, rpt.rssi_noise);
        end
        s.carrier_seen  = s.carrier_seen | rpt.carrier_flags;
        s.encoding_seen = s.encoding_seen | rpt.encoding_flags;
        if (s.peak_rate < rpt.data_rate)
            s.peak_rate = rpt.data_rate;
        return s;
    endfunction

    task automatic check_field(string field, logic [31:0] expv, logic [31:0] actv);
        if (expv !== actv)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", field, expv, actv);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        tracker_view_t due;
        if (!rst_n)
        begin
            shadow = '0;
            views_owed.delete();
            mismatches = 0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                if (views_owed.size() == 0)
                begin
                    $error("result with no request outstanding");
                    mismatches++;
                end
                else
                begin
                    due = views_owed.pop_front();
                    check_field("locked_kind", 32'(due.locked_kind),
                                32'(res.locked_kind));
                    check_field("last_signal_level", 32'(due.sig.last),
                                32'(res.last_signal_level));
                    check_field("last_noise_level", 32'(due.noi.last),
                                32'(res.last_noise_level));
                    check_field("min_signal_level", 32'(due.sig.lo),
                                32'(res.min_signal_level));
                    check_field("max_signal_level", 32'(due.sig.hi),
                                32'(res.max_signal_level));
                    check_field("min_noise_level", 32'(due.noi.lo),
                                32'(res.min_noise_level));
                    check_field("max_noise_level", 32'(due.noi.hi),
                                32'(res.max_noise_level));
                    check_field("peak_rate", 32'(due.peak_rate), 32'(res.peak_rate));
                    check_field("carrier_seen", due.carrier_seen, res.carrier_seen);
                    check_field("encoding_seen", due.encoding_seen, res.encoding_seen);
                end
            end
            if (rpt.valid && rpt.ready)
            begin
                shadow = fold_report(shadow);
                views_owed.push_back(shadow);
            end
        end
        results_owed = views_owed.size();
    end

endmodule

FILE: tb/radio_signal_level_tracker_test.sv
`timescale 1ns / 1ps
// Top of the radio signal level tracker testbench: clock, reset, request
// stimulus, result back-pressure and verdict. Depends on rslt_pkg, the two
// channel interfaces, the tracker and radio_signal_level_tracker_checker.
module radio_signal_level_tracker_test;
    import rslt_pkg::*;

    // Code 3 of the unit field has no name in the package; handled as other.
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int RandomReports = 1750;
    localparam int DrainCycles   = 8;

    logic clk = 1'b0;
    logic rst_n;
    int   mismatches;
    int   results_owed;

    rslt_rpt_if rpt ();
    rslt_lvl_if res ();

    radio_signal_level_tracker u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .rpt   (rpt),
        .res   (res)
    );

    radio_signal_level_tracker_checker u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .rpt          (rpt),
        .res          (res),
        .mismatches   (mismatches),
        .results_owed (results_owed)
    );

    always #6 clk = ~clk;

    // Sender pacing: requests go out in bursts; between bursts valid drops
    // for a random gap. A gap of zero merges two bursts into one stretch.
    int burst_left = 0;

    task automatic put_report(report_t r);
        rpt.report_present <= r.report_present;
        rpt.unit_kind      <= r.unit_kind;
        rpt.dbm_signal     <= r.dbm_signal;
        rpt.dbm_noise      <= r.dbm_noise;
        rpt.rssi_signal    <= r.rssi_signal;
        rpt.rssi_noise     <= r.rssi_noise;
        rpt.carrier_flags  <= r.carrier_flags;
        rpt.encoding_flags <= r.encoding_flags;
        rpt.data_rate      <= r.data_rate;
    endtask

    // Drive one request and hold it until the tracker takes it. Valid is
    // left high within a burst, so back-to-back requests go out with no gap.
    task automatic push_report(report_t r);
        int gap;
        put_report(r);
        rpt.valid <= 1'b1;
        do
            @(posedge clk);
        while (!rpt.ready);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                rpt.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
    endtask

    // The reading pair of the report's unit carries sig/noi; the other pair
    // gets noise so that a tracker reading the wrong pair shows up.
    function automatic report_t make_report(logic present, logic [1:0] kind,
                                            level_t sig, level_t noi, flags_t car,
                                            flags_t enc, rate_t rate);
        report_t r;
        r.report_present = present;
        r.unit_kind      = kind;
        r.dbm_signal     = level_t'($urandom);
        r.dbm_noise      = level_t'($urandom);
        r.rssi_signal    = level_t'($urandom);
        r.rssi_noise     = level_t'($urandom);
        r.carrier_flags  = car;
        r.encoding_flags = enc;
        r.data_rate      = rate;
        if (kind == KIND_RSSI)
        begin
            r.rssi_signal = sig;
            r.rssi_noise  = noi;
        end
        else
        begin
            r.dbm_signal = sig;
            r.dbm_noise  = noi;
        end
        return r;
    endfunction

    // Absent readings and both extremes show up often; the rest are either
    // realistic small levels or any 16-bit value.
    function automatic level_t random_level();
        case ($urandom_range(0, 9))
            0, 1:    return '0;
            2:       return 16'sh7FFF;
            3:       return 16'sh8000;
            4, 5:    return level_t'($urandom);
            default: return level_t'(int'($urandom_range(0, 240)) - 120);
        endcase
    endfunction

    // Mostly single bits so the flag sets fill up gradually.
    function automatic flags_t random_flags();
        case ($urandom_range(0, 23))
            0:       return '0;
            1:       return flags_t'($urandom);
            default: return flags_t'(1) << $urandom_range(0, 31);
        endcase
    endfunction

    // Rates mostly climb slowly; the full range is rare since it pins the peak.
    function automatic rate_t random_rate(int step);
        if ($urandom_range(0, 63) == 0)
            return rate_t'($urandom);
        return rate_t'($urandom_range(0, 40 + step * 30));
    endfunction

    // Well-formed traffic is mostly present reports in the locked unit; the
    // rest is the other unit, unit-less reports and absent reports.
    function automatic report_t random_report(kind_t home, kind_t away, int step);
        logic [1:0] kind;
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 12)
            kind = home;
        else if (pick < 15)
            kind = away;
        else if (pick < 17)
            kind = KIND_OTHER;
        else
            kind = KIND_UNUSED;
        return make_report($urandom_range(0, 7) != 0, kind, random_level(),
                           random_level(), random_flags(), random_flags(),
                           random_rate(step));
    endfunction

    // Request stimulus. Reset happens once, so the unit locks once per run;
    // which unit locks is left to the seed so both paths see coverage.
    initial
    begin
        kind_t home;
        kind_t away;
        rst_n     <= 1'b0;
        rpt.valid <= 1'b0;
        put_report('0);
        home = ($urandom_range(0, 1) == 0) ? KIND_DBM : KIND_RSSI;
        away = (home == KIND_DBM) ? KIND_RSSI : KIND_DBM;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // No report: flags and rate at their extremes, nothing may change.
        push_report(make_report(1'b0, home, level_t'(-30), level_t'(-90), '1, '1,
                                16'hFFFF));
        // Unit-less reports feed flags and rate but must not lock.
        push_report(make_report(1'b1, KIND_OTHER, level_t'(-50), level_t'(-80),
                                32'h0000_0001, 32'h8000_0000, 16'd12));
        push_report(make_report(1'b1, KIND_UNUSED, level_t'(-50), level_t'(-80),
                                32'h8000_0000, 32'h0000_0001, 16'd0));
        // Lock with both readings absent: kind locks, levels stay unset.
        push_report(make_report(1'b1, home, '0, '0, '0, '0, '0));
        push_report(make_report(1'b1, home, level_t'(-40), level_t'(-95),
                                32'h0000_0002, 32'h0000_0004, 16'd54));
        // One reading absent at a time.
        push_report(make_report(1'b1, home, level_t'(-20), '0, '0, '0, 16'd11));
        push_report(make_report(1'b1, home, '0, level_t'(-70), '0, '0, 16'd60));
        // Signed extremes in both orders, then the smallest magnitudes.
        push_report(make_report(1'b1, home, 16'sh7FFF, 16'sh8000, '0, '0, 16'd1));
        push_report(make_report(1'b1, home, 16'sh8000, 16'sh7FFF, '0, '0, 16'd2));
        push_report(make_report(1'b1, home, level_t'(1), level_t'(-1), '0, '0, '0));
        push_report(make_report(1'b1, home, level_t'(-1), level_t'(1), '0, '0, '0));
        // Wrong unit: levels held, flags and rate taken; absent report: none.
        push_report(make_report(1'b1, away, level_t'(-10), level_t'(-10),
                                32'h0000_0010, 32'h0000_0020, 16'd300));
        push_report(make_report(1'b0, home, level_t'(-5), level_t'(-5),
                                32'h0000_0040, 32'h0000_0080, 16'd400));
        push_report(make_report(1'b1, KIND_OTHER, '0, '0, 32'h0000_0100,
                                32'h0000_0200, 16'd100));
        push_report(make_report(1'b1, home, level_t'(-60), level_t'(-60), '0, '0,
                                16'd0));

        for (int i = 0; i < RandomReports; i++)
            push_report(random_report(home, away, i));
        rpt.valid <= 1'b0;

        // Sample the owed count away from the edge the checker updates on.
        @(negedge clk);
        while (results_owed != 0)
            @(negedge clk);
        repeat (DrainCycles) @(posedge clk);
        if (mismatches == 0)
            $display("radio_signal_level_tracker_test passed");
        else
            $display("radio_signal_level_tracker_test failed");
        $finish;
    end

    // Result back-pressure cycles through randomly drawn patterns - always
    // ready, coin flip, one cycle in three, or ready with rare stalls.
    initial
    begin
        int mode;
        int tick;
        res.ready <= 1'b0;
        mode = 0;
        tick = 0;
        forever
        begin
            @(posedge clk);
            if (tick % 48 == 0)
                mode = $urandom_range(0, 3);
            case (mode)
                0:       res.ready <= 1'b1;
                1:       res.ready <= 1'($urandom_range(0, 1));
                2:       res.ready <= (tick % 3 == 0);
                default: res.ready <= ($urandom_range(0, 7) != 0);
            endcase
            tick++;
        end
    end

    // Watchdog: a clean run needs well under a tenth of this.
    initial
    begin
        #2_000_000;
        $display("radio_signal_level_tracker_test failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/rslt_pkg.sv
rtl/core/rslt_rpt_if.sv
rtl/core/rslt_lvl_if.sv
rtl/core/rslt_in_stage.sv
rtl/core/rslt_level_unit.sv
rtl/core/radio_signal_level_tracker.sv
tb/radio_signal_level_tracker_checker.sv
tb/radio_signal_level_tracker_test.sv
